// ===== rtl/core/siops_pkg.sv =====
// Package for the serial I/O pin sequencer: payload types, pin masks, codes.
package siops_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_SCALE       = 2'd1;
    localparam logic [1:0] REG_LOAD_OUT    = 2'd2;

    localparam logic [1:0] MODE_OUTPUT  = 2'd0;
    localparam logic [1:0] MODE_DIGITAL = 2'd1;
    localparam logic [1:0] MODE_ANA_X   = 2'd2;
    localparam logic [1:0] MODE_ANA_Y   = 2'd3;

    localparam logic [5:0] PIN_LOAD_OUT = 6'h01;
    localparam logic [5:0] PIN_LOAD_IN  = 6'h02;
    localparam logic [5:0] PIN_DATA     = 6'h04;
    localparam logic [5:0] PIN_CLOCK    = 6'h08;
    localparam logic [5:0] PIN_TRIG_X   = 6'h10;
    localparam logic [5:0] PIN_TRIG_Y   = 6'h20;
    localparam logic [5:0] PIN_TRIGS    = PIN_TRIG_X | PIN_TRIG_Y;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_OUT_LO    = 9'b000000010,
        PH_OUT_HI    = 9'b000000100,
        PH_DIG_LOAD  = 9'b000001000,
        PH_DIG_LDCLK = 9'b000010000,
        PH_DIG_LO    = 9'b000100000,
        PH_DIG_HI    = 9'b001000000,
        PH_ANA_PULSE = 9'b010000000,
        PH_ANA_COUNT = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic [1:0] mode;
        logic [7:0] out_byte;
        logic       busy_pin;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  pins;
        logic        ready_res;
        logic        done_res;
        logic [7:0]  digital_value;
        logic [15:0] analog_count;
        logic        analog_overflow;
    } t_out_item;

endpackage

// ===== rtl/core/serial_io_pin_sequencer_core.sv =====
// Serial I/O pin sequencer top level: tick pipeline, command sequencer, APB registers.
//
// Usage: every input transfer is one timing tick carrying start_req, mode,
// out_byte and the sampled busy pin. Every input transfer yields exactly one
// output transfer with the six pin levels, ready/done flags and the last
// digital byte and analog count.
// Path: an accepted input transfer is captured in the input register; the
// sequencer state is then advanced from it and the result written to the output
// register by the same update, which waits while the output is stalled.
// Throughput: one transfer per cycle unless the output stalls; the state update
// is a single pass of logic between the input register and the output register.
// Stall: when the output register is full and i_out_stall is high, the input
// register holds and o_in_stall rises once it is occupied; no tick is lost.
// Reset: pipeline empty, sequencer idle, pins at both triggers high (0x30),
// last results zero, registers at half period 1, scale 4, load-out off.
// Registers (APB, 32-bit words): 0x0 half period ticks, 0x4 scale ticks,
// 0x8 load-out during input commands. Write only while no ticks are in flight.
module serial_io_pin_sequencer_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  siops_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output siops_pkg::t_out_item                  o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [siops_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [siops_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [siops_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                  pready
);
    import siops_pkg::*;

    // configuration
    logic [7:0] r_half;
    logic [7:0] r_scale;
    logic       r_lo_en;
    logic       cfg_wr;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;

    // sequencer state
    t_phase                 r_phase,   n_phase;
    logic [2:0]             r_bit,     n_bit;
    logic [7:0]             r_wait,    n_wait;
    logic [7:0]             r_shift,   n_shift;
    logic [5:0]             r_pins,    n_pins;
    logic [COUNT_WIDTH-1:0] r_count,   n_count;
    logic                   r_sat,     n_sat;
    logic [7:0]             r_last_dig, n_last_dig;
    logic [COUNT_WIDTH-1:0] r_last_ana, n_last_ana;
    logic                   r_last_ovf, n_last_ovf;
    logic                   done;

    logic [7:0]             hold_wait;
    logic [7:0]             scale_wait;
    logic [5:0]             lo_bit;
    logic [2:0]             bit_dec;
    logic [COUNT_WIDTH-1:0] count_inc;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_HALF_PERIOD: prdata = {{(APB_DATA_WIDTH-8){1'b0}}, r_half};
            REG_SCALE:       prdata = {{(APB_DATA_WIDTH-8){1'b0}}, r_scale};
            REG_LOAD_OUT:    prdata = {{(APB_DATA_WIDTH-1){1'b0}}, r_lo_en};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 8'd1;
            r_scale <= 8'd4;
            r_lo_en <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HALF_PERIOD: r_half  <= pwdata[7:0];
                REG_SCALE:       r_scale <= pwdata[7:0];
                REG_LOAD_OUT:    r_lo_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // sequencer next state
    assign hold_wait  = (r_half  == 8'd0) ? 8'd0 : r_half  - 8'd1;
    assign scale_wait = (r_scale == 8'd0) ? 8'd0 : r_scale - 8'd1;
    assign lo_bit     = r_lo_en ? PIN_LOAD_OUT : 6'h00;
    assign bit_dec    = r_bit - 3'd1;
    assign count_inc  = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_wait     = r_wait;
        n_shift    = r_shift;
        n_pins     = r_pins;
        n_count    = r_count;
        n_sat      = r_sat;
        n_last_dig = r_last_dig;
        n_last_ana = r_last_ana;
        n_last_ovf = r_last_ovf;
        done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (r_in.start_req) begin
                n_wait = hold_wait;
                n_bit  = 3'd7;
                case (r_in.mode)
                    MODE_OUTPUT: begin
                        n_shift = r_in.out_byte;
                        n_pins  = PIN_TRIGS | (r_in.out_byte[7] ? PIN_DATA : 6'h00);
                        n_phase = PH_OUT_LO;
                    end
                    MODE_DIGITAL: begin
                        n_shift = 8'h00;
                        n_pins  = PIN_TRIGS | PIN_LOAD_IN | lo_bit;
                        n_phase = PH_DIG_LOAD;
                    end
                    default: begin
                        n_bit   = r_bit;
                        n_count = '0;
                        n_sat   = 1'b0;
                        n_pins  = ((r_in.mode == MODE_ANA_Y) ? PIN_TRIG_X : PIN_TRIG_Y)
                                  | PIN_CLOCK | lo_bit;
                        n_phase = PH_ANA_PULSE;
                    end
                endcase
            end
        end else if (r_wait != 8'd0) begin
            n_wait = r_wait - 8'd1;
        end else begin
            case (r_phase)
                PH_OUT_LO: begin
                    n_pins  = r_pins | PIN_CLOCK;
                    n_phase = PH_OUT_HI;
                    n_wait  = hold_wait;
                end
                PH_OUT_HI: begin
                    if (r_bit == 3'd0) begin
                        n_pins  = PIN_TRIGS | PIN_LOAD_OUT | PIN_CLOCK;
                        n_phase = PH_IDLE;
                        n_wait  = 8'd0;
                        done    = 1'b1;
                    end else begin
                        n_bit   = bit_dec;
                        n_pins  = PIN_TRIGS | (r_shift[bit_dec] ? PIN_DATA : 6'h00);
                        n_phase = PH_OUT_LO;
                        n_wait  = hold_wait;
                    end
                end
                PH_DIG_LOAD: begin
                    n_pins  = r_pins | PIN_CLOCK;
                    n_phase = PH_DIG_LDCLK;
                    n_wait  = hold_wait;
                end
                PH_DIG_LDCLK, PH_DIG_HI: begin
                    if (r_in.busy_pin) begin
                        n_shift[r_bit] = 1'b1;
                    end
                    n_pins  = PIN_TRIGS | lo_bit;
                    n_phase = PH_DIG_LO;
                    n_wait  = hold_wait;
                end
                PH_DIG_LO: begin
                    n_pins = r_pins | PIN_CLOCK;
                    if (r_bit == 3'd0) begin
                        n_phase    = PH_IDLE;
                        n_wait     = 8'd0;
                        n_last_dig = r_shift;
                        done       = 1'b1;
                    end else begin
                        n_bit   = bit_dec;
                        n_phase = PH_DIG_HI;
                        n_wait  = hold_wait;
                    end
                end
                PH_ANA_PULSE, PH_ANA_COUNT: begin
                    if (r_phase == PH_ANA_PULSE) begin
                        n_pins = PIN_TRIGS | PIN_CLOCK | lo_bit;
                    end
                    if (r_in.busy_pin) begin
                        n_count = count_inc;
                        n_sat   = r_sat || (count_inc == COUNT_MAX);
                        n_phase = PH_ANA_COUNT;
                        n_wait  = scale_wait;
                    end else begin
                        n_last_ana = r_count;
                        n_last_ovf = r_sat;
                        n_phase    = PH_IDLE;
                        n_wait     = 8'd0;
                        done       = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_wait  = 8'd0;
                end
            endcase
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_bit       <= 3'd0;
            r_wait      <= 8'd0;
            r_shift     <= 8'h00;
            r_pins      <= PIN_TRIGS;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_last_dig  <= 8'h00;
            r_last_ana  <= '0;
            r_last_ovf  <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_phase    <= n_phase;
                r_bit      <= n_bit;
                r_wait     <= n_wait;
                r_shift    <= n_shift;
                r_pins     <= n_pins;
                r_count    <= n_count;
                r_sat      <= n_sat;
                r_last_dig <= n_last_dig;
                r_last_ana <= n_last_ana;
                r_last_ovf <= n_last_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out.pins            <= n_pins;
            r_out.ready_res       <= (n_phase == PH_IDLE);
            r_out.done_res        <= done;
            r_out.digital_value   <= n_last_dig;
            r_out.analog_count    <= 16'(n_last_ana);
            r_out.analog_overflow <= n_last_ovf;
        end
    end

endmodule

// ===== tb/sv/serial_io_pin_sequencer_core_tb.sv =====
// Testbench for the serial I/O pin sequencer core: tick stimulus, per-tick pin prediction, checks.
module serial_io_pin_sequencer_core_tb;
    import siops_pkg::*;

    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_LIMIT   = 40;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    t_in_item                  i_in_data;
    logic                      o_out_valid;
    logic                      i_out_stall;
    t_out_item                 o_out_data;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    serial_io_pin_sequencer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // sequencer copy used for prediction
    t_phase                 seq_phase;
    logic [3:0]             seq_bit;
    logic [7:0]             seq_wait;
    logic [7:0]             seq_shift;
    logic [5:0]             seq_pins;
    logic [COUNT_WIDTH-1:0] seq_count;
    logic                   seq_sat;
    logic [7:0]             last_digital;
    logic [15:0]            last_analog;
    logic                   last_overflow;
    logic [7:0]             cfg_half_period;
    logic [7:0]             cfg_scale;
    logic                   cfg_load_out;

    t_out_item pending_pin_results[$];

    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    bit hold_request     = 1'b0;
    int hold_left        = 0;
    int mismatches       = 0;
    int results_checked  = 0;
    int ticks_sent       = 0;
    int command_ticks    = 0;
    int reg_writes       = 0;
    int in_stall_cycles  = 0;
    int saturations      = 0;
    int cmds_by_mode[4]  = '{0, 0, 0, 0};

    function automatic void move_to(input logic [5:0] lvl, input t_phase nxt,
                                    input logic [7:0] ticks);
        seq_pins  = lvl;
        seq_phase = nxt;
        seq_wait  = ticks - 8'd1;
    endfunction

    function automatic logic sample_busy_count(input logic busy);
        if (busy) begin
            if (seq_count < COUNT_MAX)
                seq_count = seq_count + 1'b1;
            if (seq_count == COUNT_MAX)
                seq_sat = 1'b1;
            seq_phase = PH_ANA_COUNT;
            seq_wait  = ((cfg_scale == 8'd0) ? 8'd1 : cfg_scale) - 8'd1;
            return 1'b0;
        end
        last_analog   = seq_count;
        last_overflow = seq_sat;
        seq_phase     = PH_IDLE;
        seq_wait      = 8'd0;
        return 1'b1;
    endfunction

    function automatic t_out_item step_sequencer(input t_in_item it);
        t_out_item  r;
        logic [7:0] hold;
        logic [5:0] lo;
        logic       fin;
        hold = (cfg_half_period == 8'd0) ? 8'd1 : cfg_half_period;
        lo   = cfg_load_out ? PIN_LOAD_OUT : 6'd0;
        fin  = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (it.start_req) begin
                case (it.mode)
                    MODE_OUTPUT: begin
                        seq_shift = it.out_byte;
                        seq_bit   = 4'd7;
                        move_to(PIN_TRIGS | (it.out_byte[7] ? PIN_DATA : 6'd0), PH_OUT_LO, hold);
                    end
                    MODE_DIGITAL: begin
                        seq_shift = 8'd0;
                        seq_bit   = 4'd7;
                        move_to(PIN_TRIGS | PIN_LOAD_IN | lo, PH_DIG_LOAD, hold);
                    end
                    default: begin
                        seq_count = '0;
                        seq_sat   = 1'b0;
                        move_to(((it.mode == MODE_ANA_Y) ? PIN_TRIG_X : PIN_TRIG_Y) | PIN_CLOCK | lo,
                                PH_ANA_PULSE, hold);
                    end
                endcase
            end
        end else if (seq_wait != 8'd0) begin
            seq_wait = seq_wait - 8'd1;
        end else begin
            case (seq_phase)
                PH_OUT_LO: move_to(seq_pins | PIN_CLOCK, PH_OUT_HI, hold);
                PH_OUT_HI: begin
                    if (seq_bit == 4'd0) begin
                        move_to(PIN_TRIGS | PIN_LOAD_OUT | PIN_CLOCK, PH_IDLE, 8'd1);
                        fin = 1'b1;
                    end else begin
                        seq_bit = seq_bit - 4'd1;
                        move_to(PIN_TRIGS | (seq_shift[seq_bit[2:0]] ? PIN_DATA : 6'd0),
                                PH_OUT_LO, hold);
                    end
                end
                PH_DIG_LOAD: move_to(seq_pins | PIN_CLOCK, PH_DIG_LDCLK, hold);
                PH_DIG_LDCLK, PH_DIG_HI: begin
                    if (it.busy_pin)
                        seq_shift[seq_bit[2:0]] = 1'b1;
                    move_to(PIN_TRIGS | lo, PH_DIG_LO, hold);
                end
                PH_DIG_LO: begin
                    if (seq_bit == 4'd0) begin
                        move_to(seq_pins | PIN_CLOCK, PH_IDLE, 8'd1);
                        last_digital = seq_shift;
                        fin = 1'b1;
                    end else begin
                        seq_bit = seq_bit - 4'd1;
                        move_to(seq_pins | PIN_CLOCK, PH_DIG_HI, hold);
                    end
                end
                PH_ANA_PULSE: begin
                    seq_pins = PIN_TRIGS | PIN_CLOCK | lo;
                    fin = sample_busy_count(it.busy_pin);
                end
                PH_ANA_COUNT: fin = sample_busy_count(it.busy_pin);
                default: begin
                    seq_phase = PH_IDLE;
                    seq_wait  = 8'd0;
                end
            endcase
        end
        r.pins            = seq_pins;
        r.ready_res       = (seq_phase == PH_IDLE);
        r.done_res        = fin;
        r.digital_value   = last_digital;
        r.analog_count    = last_analog;
        r.analog_overflow = last_overflow;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, results_checked);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic send_tick(input logic start, input logic [1:0] mode,
                             input logic [7:0] byte_val, input logic busy);
        t_in_item it;
        it.start_req = start;
        it.mode      = mode;
        it.out_byte  = byte_val;
        it.busy_pin  = busy;
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_pin_results.push_back(step_sequencer(it));
        ticks_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_pin_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_pin_results.size() != 0) begin
            report_mismatch("results never delivered", pending_pin_results.size(), 0);
            pending_pin_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] want;
        logic [31:0] mask;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_HALF_PERIOD: cfg_half_period = value;
            REG_SCALE:       cfg_scale = value;
            REG_LOAD_OUT:    cfg_load_out = value[0];
            default: ;
        endcase
        mask = (idx == REG_LOAD_OUT) ? 32'h1 : 32'hFF;
        want = {24'd0, value} & mask;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        compare_field("register readback", prdata & mask, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    // start tick, then ticks until the sequencer is idle again
    task automatic run_command(input logic [1:0] mode, input logic [7:0] byte_val,
                               input int high_ticks, input bit random_busy, input bit noisy);
        int   k;
        logic busy;
        send_tick(1'b1, mode, byte_val, 1'($urandom_range(1)));
        cmds_by_mode[mode]++;
        k = 0;
        while (seq_phase != PH_IDLE) begin
            busy = random_busy ? 1'($urandom_range(1)) : (k < high_ticks);
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, 2'($urandom_range(3)),
                      8'($urandom_range(255)), busy);
            k++;
        end
        command_ticks += k + 1;
    endtask

    task automatic test_after_reset();
        repeat (6)
            send_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
    endtask

    task automatic test_each_command();
        run_command(MODE_OUTPUT, 8'h00, 0, 1'b0, 1'b0);
        run_command(MODE_OUTPUT, 8'hFF, 0, 1'b0, 1'b1);
        run_command(MODE_OUTPUT, 8'hA5, 0, 1'b0, 1'b0);
        run_command(MODE_DIGITAL, 8'h00, 1000, 1'b0, 1'b0);
        run_command(MODE_DIGITAL, 8'hFF, 0, 1'b0, 1'b1);
        run_command(MODE_DIGITAL, 8'h3C, 0, 1'b1, 1'b0);
        run_command(MODE_ANA_X, 8'h00, 0, 1'b0, 1'b0);
        run_command(MODE_ANA_Y, 8'h00, 12, 1'b0, 1'b1);
        run_command(MODE_ANA_X, 8'h00, 0, 1'b1, 1'b0);
    endtask

    task automatic test_load_out_option();
        write_register(REG_LOAD_OUT, 8'd1);
        run_command(MODE_DIGITAL, 8'h00, 0, 1'b1, 1'b1);
        run_command(MODE_ANA_Y, 8'h00, 8, 1'b0, 1'b0);
        run_command(MODE_ANA_X, 8'h00, 5, 1'b0, 1'b1);
        run_command(MODE_OUTPUT, 8'h5A, 0, 1'b0, 1'b0);
        write_register(REG_LOAD_OUT, 8'd0);
    endtask

    task automatic test_zero_periods();
        write_register(REG_HALF_PERIOD, 8'd0);
        write_register(REG_SCALE, 8'd0);
        run_command(MODE_OUTPUT, 8'($urandom_range(255)), 0, 1'b0, 1'b1);
        run_command(MODE_DIGITAL, 8'h00, 0, 1'b1, 1'b0);
        run_command(MODE_ANA_X, 8'h00, 10, 1'b0, 1'b0);
        run_command(MODE_ANA_Y, 8'h00, 0, 1'b1, 1'b1);
    endtask

    task automatic test_long_periods();
        write_register(REG_HALF_PERIOD, 8'd12);
        write_register(REG_SCALE, 8'd12);
        run_command(MODE_OUTPUT, 8'h81, 0, 1'b0, 1'b1);
        run_command(MODE_ANA_Y, 8'h00, 60, 1'b0, 1'b0);
        write_register(REG_HALF_PERIOD, 8'd1);
        write_register(REG_SCALE, 8'd1);
    endtask

    task automatic test_input_backpressure();
        int saved_gap;
        int start_ticks;
        write_register(REG_HALF_PERIOD, 8'd2);
        write_register(REG_SCALE, 8'd2);
        saved_gap      = sender_gap_pct;
        sender_gap_pct = 0;
        hold_request   = 1'b1;
        start_ticks    = command_ticks;
        while (command_ticks - start_ticks < 160)
            run_command(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(20),
                        1'b1, 1'b1);
        sender_gap_pct = saved_gap;
        drain_results();
    endtask

    task automatic test_random_mix(input int target);
        int   start_ticks;
        int   n_cmds;
        logic [1:0] mode;
        int   scale_eff;
        start_ticks = command_ticks;
        n_cmds      = 0;
        while (command_ticks - start_ticks < target) begin
            if (n_cmds % 6 == 0) begin
                write_register(REG_HALF_PERIOD, ($urandom_range(9) == 0) ? 8'd0
                                                : 8'($urandom_range(1, 5)));
                write_register(REG_SCALE, 8'($urandom_range(6)));
                write_register(REG_LOAD_OUT, 8'($urandom_range(1)));
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4))
                    send_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            mode      = 2'($urandom_range(3));
            scale_eff = (cfg_scale == 8'd0) ? 1 : cfg_scale;
            if (mode == MODE_ANA_X || mode == MODE_ANA_Y)
                run_command(mode, 8'($urandom_range(255)), $urandom_range(12 * scale_eff),
                            $urandom_range(9) == 0, 1'($urandom_range(1)));
            else
                run_command(mode, 8'($urandom_range(255)), 0, 1'b1, 1'($urandom_range(1)));
            n_cmds++;
        end
    endtask

    initial begin : result_monitor
        t_out_item want;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_stall)
                in_stall_cycles++;
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_pin_results.size() == 0) begin
                    report_mismatch("transfer with no result expected",
                                    32'(o_out_data.pins), 32'd0);
                end else begin
                    want = pending_pin_results.pop_front();
                    compare_field("pins", 32'(o_out_data.pins), 32'(want.pins));
                    compare_field("ready_res", 32'(o_out_data.ready_res),
                                  32'(want.ready_res));
                    compare_field("done_res", 32'(o_out_data.done_res),
                                  32'(want.done_res));
                    compare_field("digital_value", 32'(o_out_data.digital_value),
                                  32'(want.digital_value));
                    compare_field("analog_count", 32'(o_out_data.analog_count),
                                  32'(want.analog_count));
                    compare_field("analog_overflow", 32'(o_out_data.analog_overflow),
                                  32'(want.analog_overflow));
                    if (want.done_res && want.analog_overflow)
                        saturations++;
                end
                results_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_gap_pct);
            end
        end
    end

    initial begin : watchdog
        #24_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        seq_phase       = PH_IDLE;
        seq_bit         = 4'd0;
        seq_wait        = 8'd0;
        seq_shift       = 8'd0;
        seq_pins        = PIN_TRIGS;
        seq_count       = '0;
        seq_sat         = 1'b0;
        last_digital    = 8'd0;
        last_analog     = 16'd0;
        last_overflow   = 1'b0;
        cfg_half_period = 8'd1;
        cfg_scale       = 8'd4;
        cfg_load_out    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gap_pct   = 37;
        receiver_gap_pct = 47;
        test_after_reset();
        test_each_command();
        test_load_out_option();
        test_zero_periods();
        test_random_mix(250);

        sender_gap_pct   = 47;
        receiver_gap_pct = 37;
        test_long_periods();
        test_input_backpressure();
        test_random_mix(150);

        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        test_random_mix(150);
        drain_results();

        $display("Covered %0d ticks, %0d results; commands: output %0d, digital %0d",
                 ticks_sent, results_checked, cmds_by_mode[MODE_OUTPUT],
                 cmds_by_mode[MODE_DIGITAL]);
        $display("Analog X %0d, analog Y %0d, register writes %0d, input stall cycles %0d",
                 cmds_by_mode[MODE_ANA_X], cmds_by_mode[MODE_ANA_Y], reg_writes,
                 in_stall_cycles);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== serial_io_pin_sequencer_core.f =====
rtl/core/siops_pkg.sv
rtl/core/serial_io_pin_sequencer_core.sv
tb/sv/serial_io_pin_sequencer_core_tb.sv
